@@ rtl/ypcb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the yaw/pitch camera basis.
// Used by every module of the block; depends on nothing else.
package ypcb_pkg;

  // Field widths
  localparam int DELTA_W = 16;
  localparam int SENS_W  = 16;
  localparam int VEC_W   = 16;
  localparam int ANGLE_W = 25;
  localparam int PROD_W  = DELTA_W + SENS_W + 1;
  localparam int ACC_W   = 34;
  localparam int XY_W    = 32;
  localparam int RND_W   = XY_W + 1 - 15;

  // Angles are degrees with 16 fraction bits
  localparam int DEG_ONE      = 65536;
  localparam int FULL_TURN    = 360 * DEG_ONE;
  localparam int HALF_TURN    = 180 * DEG_ONE;
  localparam int QUARTER_TURN = 90 * DEG_ONE;
  localparam int PITCH_MAX    = 89 * DEG_ONE;

  localparam logic signed [ANGLE_W-1:0] HALF_S      = ANGLE_W'(HALF_TURN);
  localparam logic signed [ANGLE_W-1:0] QUARTER_S   = ANGLE_W'(QUARTER_TURN);
  localparam logic signed [ANGLE_W-1:0] PITCH_MAX_S = ANGLE_W'(PITCH_MAX);
  localparam logic [ANGLE_W-1:0]        FULL_U      = ANGLE_W'(FULL_TURN);
  localparam logic [ANGLE_W-1:0]        HALF_U      = ANGLE_W'(HALF_TURN);

  // Modulo reduction: subtract FULL_TURN << k for k = RED_SHIFTS-1 down to 0
  localparam int RED_SHIFTS = 8;
  localparam int RED_W      = $clog2(RED_SHIFTS);
  localparam logic [RED_W-1:0] RED_LAST   = RED_W'(RED_SHIFTS - 1);
  localparam logic [ACC_W-1:0] FULL_ACC   = ACC_W'(FULL_TURN);
  localparam logic [ACC_W-1:0] RED_OFFSET = FULL_ACC << (RED_SHIFTS - 1);

  // Sine/cosine iteration
  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                   TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int STEP_W          = $clog2(ATAN_ENTRIES);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam logic signed [XY_W-1:0] ONE_Q30     = XY_W'(1073741824);

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SENS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = CFG_IDX_W'(1);
  localparam logic [SENS_W-1:0]    SENS_RESET      = SENS_W'(6554);

  typedef struct packed {
    logic signed [VEC_W-1:0] sine;
    logic signed [VEC_W-1:0] cosine;
  } sincos_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
  function automatic logic signed [ANGLE_W-1:0] atan_deg(input logic [STEP_W-1:0] idx);
    logic signed [ANGLE_W-1:0] v;
    unique case (idx)
      5'd0:    v = ANGLE_W'(2949120);
      5'd1:    v = ANGLE_W'(1740967);
      5'd2:    v = ANGLE_W'(919879);
      5'd3:    v = ANGLE_W'(466945);
      5'd4:    v = ANGLE_W'(234379);
      5'd5:    v = ANGLE_W'(117304);
      5'd6:    v = ANGLE_W'(58666);
      5'd7:    v = ANGLE_W'(29335);
      5'd8:    v = ANGLE_W'(14668);
      5'd9:    v = ANGLE_W'(7334);
      5'd10:   v = ANGLE_W'(3667);
      5'd11:   v = ANGLE_W'(1833);
      5'd12:   v = ANGLE_W'(917);
      5'd13:   v = ANGLE_W'(458);
      5'd14:   v = ANGLE_W'(229);
      5'd15:   v = ANGLE_W'(115);
      5'd16:   v = ANGLE_W'(57);
      5'd17:   v = ANGLE_W'(29);
      5'd18:   v = ANGLE_W'(14);
      5'd19:   v = ANGLE_W'(7);
      5'd20:   v = ANGLE_W'(4);
      5'd21:   v = ANGLE_W'(2);
      5'd22:   v = ANGLE_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a rounded value to Q1.15
  function automatic logic signed [VEC_W-1:0] sat16(input logic signed [RND_W-1:0] v);
    logic signed [VEC_W-1:0] r;
    if (v > RND_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -RND_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[VEC_W-1:0];
    end
    return r;
  endfunction

  // Negate with saturation: -(-1.0) becomes the largest positive code
  function automatic logic signed [VEC_W-1:0] neg_sat16(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] r;
    if (v == 16'sh8000) begin
      r = 16'sh7FFF;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // Round half up from 30 fraction bits to 15, then saturate
  function automatic logic signed [VEC_W-1:0] round_q30(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] s;
    s = {v[XY_W-1], v} + (XY_W+1)'(16384);
    return sat16(s[XY_W:15]);
  endfunction

endpackage

@@ rtl/yaw_pitch_camera_basis.sv @@
`timescale 1ns / 1ps
// Yaw/pitch camera basis. Each word takes one pass of the 8-step modulo reducer
// for the yaw, a second for the pitch when it wraps instead of clamping, and two
// passes of the shared CORDIC; an angle of exactly +-90 degrees needs no
// micro-rotations. One word in flight, the next taken the cycle after the result
// is parked. Reset zeroes the angles.
module yaw_pitch_camera_basis (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ypcb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ypcb_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [ypcb_pkg::DELTA_W-1:0]    mouse_dx_i,
  input  logic signed [ypcb_pkg::DELTA_W-1:0]    mouse_dy_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ypcb_pkg::VEC_W-1:0]      front_x_o,
  output logic signed [ypcb_pkg::VEC_W-1:0]      front_y_o,
  output logic signed [ypcb_pkg::VEC_W-1:0]      front_z_o,
  output logic signed [ypcb_pkg::VEC_W-1:0]      right_x_o,
  output logic signed [ypcb_pkg::VEC_W-1:0]      right_y_o,
  output logic signed [ypcb_pkg::VEC_W-1:0]      right_z_o,
  output logic signed [ypcb_pkg::VEC_W-1:0]      up_x_o,
  output logic signed [ypcb_pkg::VEC_W-1:0]      up_y_o,
  output logic signed [ypcb_pkg::VEC_W-1:0]      up_z_o,
  output logic [ypcb_pkg::ANGLE_W-1:0]           yaw_now_o,
  output logic signed [ypcb_pkg::ANGLE_W-1:0]    pitch_now_o,
  output logic                                   degenerate_o
);
  import ypcb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULX,
    S_YAW,
    S_YAW_W,
    S_PITCH_W,
    S_TRIG_Y,
    S_TRIG_Y_W,
    S_TRIG_P_W,
    S_MUL,
    S_OUT
  } state_e;

  state_e state_q;

  logic [SENS_W-1:0]         sens_q;
  logic                      limit_q;
  logic [ANGLE_W-1:0]        yaw_q;
  logic signed [ANGLE_W-1:0] pitch_q;

  logic signed [DELTA_W-1:0] dx_q, dy_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [DELTA_W-1:0] mul_x;
  logic signed [SENS_W:0]    sens_s;

  logic signed [VEC_W-1:0]   sy_q, cy_q, sp_q, cp_q;
  logic signed [VEC_W-1:0]   mres_q [4];
  logic [1:0]                mcnt_q;
  logic signed [VEC_W-1:0]   mul_a, mul_b, mul_p;

  // angle update arithmetic
  logic signed [ACC_W:0]     prod_ext, yaw_sum, pitch_raw, pitch_sum;
  logic signed [ANGLE_W-1:0] pitch_clamp, yaw_signed;

  logic                      red_start, red_done;
  logic [ACC_W-1:0]          red_operand;
  logic [ANGLE_W-1:0]        red_result;

  logic                      cor_start, cor_done;
  logic signed [ANGLE_W-1:0] cor_angle;
  sincos_t                   cor_res;

  logic                      out_load, out_valid_q;
  logic                      degen, cp_pos;

  logic signed [VEC_W-1:0]   front_x_q, front_y_q, front_z_q;
  logic signed [VEC_W-1:0]   right_x_q, right_z_q;
  logic signed [VEC_W-1:0]   up_x_q, up_y_q, up_z_q;
  logic [ANGLE_W-1:0]        yaw_now_q;
  logic signed [ANGLE_W-1:0] pitch_now_q;
  logic                      degen_q;

  ypcb_reduce u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (red_start),
    .operand_i (red_operand),
    .done_o    (red_done),
    .result_o  (red_result)
  );

  ypcb_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cor_start),
    .angle_i  (cor_angle),
    .done_o   (cor_done),
    .result_o (cor_res)
  );

  ypcb_mulq15 u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  // delta times sensitivity, x in the first cycle and y in the next
  always_comb begin
    mul_x  = (state_q == S_MULX) ? dx_q : dy_q;
    sens_s = {1'b0, sens_q};
    prod_d = PROD_W'(mul_x * sens_s);
  end

  // offsets keep the reducer operand positive and below 256 full turns
  always_comb begin
    prod_ext  = {{(ACC_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    yaw_sum   = $signed({{(ACC_W+1-ANGLE_W){1'b0}}, yaw_q}) + prod_ext
              + $signed({1'b0, RED_OFFSET});
    pitch_raw = $signed({{(ACC_W+1-ANGLE_W){pitch_q[ANGLE_W-1]}}, pitch_q}) - prod_ext;
    pitch_sum = pitch_raw + $signed({1'b0, RED_OFFSET})
              + $signed((ACC_W+1)'(HALF_TURN));
    if (pitch_raw > $signed((ACC_W+1)'(PITCH_MAX))) begin
      pitch_clamp = PITCH_MAX_S;
    end else if (pitch_raw < -$signed((ACC_W+1)'(PITCH_MAX))) begin
      pitch_clamp = -PITCH_MAX_S;
    end else begin
      pitch_clamp = pitch_raw[ANGLE_W-1:0];
    end
    yaw_signed = (yaw_q >= HALF_U) ? $signed(yaw_q - FULL_U) : $signed(yaw_q);
  end

  always_comb begin
    red_start   = (state_q == S_YAW) || (state_q == S_YAW_W && red_done && !limit_q);
    red_operand = (state_q == S_YAW) ? yaw_sum[ACC_W-1:0] : pitch_sum[ACC_W-1:0];
    cor_start   = (state_q == S_TRIG_Y) || (state_q == S_TRIG_Y_W && cor_done);
    cor_angle   = (state_q == S_TRIG_Y) ? yaw_signed : pitch_q;
    mul_a       = mcnt_q[0] ? sy_q : cy_q;
    mul_b       = mcnt_q[1] ? sp_q : cp_q;
    out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
    degen       = (cp_q == '0);
    cp_pos      = !cp_q[VEC_W-1] && !degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sens_q      <= SENS_RESET;
      limit_q     <= 1'b1;
      yaw_q       <= '0;
      pitch_q     <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_SENSITIVITY) begin
          sens_q <= cfg_data_i[SENS_W-1:0];
        end else if (cfg_index_i == CFG_PITCH_LIMIT) begin
          limit_q <= cfg_data_i[0];
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MULX;
          end
        end
        S_MULX: state_q <= S_YAW;
        S_YAW:  state_q <= S_YAW_W;
        S_YAW_W: begin
          if (red_done) begin
            yaw_q <= red_result;
            if (limit_q) begin
              pitch_q <= pitch_clamp;
              state_q <= S_TRIG_Y;
            end else begin
              state_q <= S_PITCH_W;
            end
          end
        end
        S_PITCH_W: begin
          if (red_done) begin
            pitch_q <= $signed(red_result - HALF_U);
            state_q <= S_TRIG_Y;
          end
        end
        S_TRIG_Y: state_q <= S_TRIG_Y_W;
        S_TRIG_Y_W: begin
          if (cor_done) begin
            state_q <= S_TRIG_P_W;
          end
        end
        S_TRIG_P_W: begin
          if (cor_done) begin
            mcnt_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          mcnt_q <= mcnt_q + 2'd1;
          if (mcnt_q == 2'd3) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      dx_q <= mouse_dx_i;
      dy_q <= mouse_dy_i;
    end
    if (state_q == S_MULX || state_q == S_YAW) begin
      prod_q <= prod_d;
    end
    if (state_q == S_TRIG_Y_W && cor_done) begin
      sy_q <= cor_res.sine;
      cy_q <= cor_res.cosine;
    end
    if (state_q == S_TRIG_P_W && cor_done) begin
      sp_q <= cor_res.sine;
      cp_q <= cor_res.cosine;
    end
    if (state_q == S_MUL) begin
      mres_q[mcnt_q] <= mul_p;
    end
    if (out_load) begin
      // products in order: cy*cp, sy*cp, cy*sp, sy*sp
      front_x_q   <= mres_q[0];
      front_y_q   <= sp_q;
      front_z_q   <= mres_q[1];
      right_x_q   <= degen ? '0 : (cp_pos ? neg_sat16(sy_q) : sy_q);
      right_z_q   <= degen ? '0 : (cp_pos ? cy_q : neg_sat16(cy_q));
      up_x_q      <= degen ? '0 : (cp_pos ? neg_sat16(mres_q[2]) : mres_q[2]);
      up_y_q      <= degen ? '0 : (cp_pos ? cp_q : neg_sat16(cp_q));
      up_z_q      <= degen ? '0 : (cp_pos ? neg_sat16(mres_q[3]) : mres_q[3]);
      yaw_now_q   <= yaw_q;
      pitch_now_q <= pitch_q;
      degen_q     <= degen;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign front_x_o    = front_x_q;
  assign front_y_o    = front_y_q;
  assign front_z_o    = front_z_q;
  assign right_x_o    = right_x_q;
  assign right_y_o    = '0;
  assign right_z_o    = right_z_q;
  assign up_x_o       = up_x_q;
  assign up_y_o       = up_y_q;
  assign up_z_o       = up_z_q;
  assign yaw_now_o    = yaw_now_q;
  assign pitch_now_o  = pitch_now_q;
  assign degenerate_o = degen_q;

endmodule

@@ rtl/ypcb_reduce.sv @@
`timescale 1ns / 1ps
// Iterative modulo-360-degree reducer: one compare and subtract per cycle.
// Depends on ypcb_pkg.
module ypcb_reduce (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ypcb_pkg::ACC_W-1:0]   operand_i,
  output logic                         done_o,
  output logic [ypcb_pkg::ANGLE_W-1:0] result_o
);
  import ypcb_pkg::*;

  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] sub;
  logic [RED_W-1:0] k_q, k_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  always_comb begin
    sub    = FULL_ACC << k_q;
    acc_d  = acc_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (acc_q >= sub) begin
        acc_d = acc_q - sub;
      end
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        k_d = k_q - RED_W'(1);
      end
    end else if (start_i) begin
      acc_d  = operand_i;
      k_d    = RED_LAST;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      k_q    <= k_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o   = done_q;
  assign result_o = acc_q[ANGLE_W-1:0];

endmodule

@@ rtl/ypcb_cordic.sv @@
`timescale 1ns / 1ps
// Rotation-mode CORDIC on angles in degrees: one micro-rotation per cycle.
// Depends on ypcb_pkg.
module ypcb_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [ypcb_pkg::ANGLE_W-1:0] angle_i,
  output logic                                done_o,
  output ypcb_pkg::sincos_t                   result_o
);
  import ypcb_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FINISH
  } cstate_e;

  cstate_e state_q;

  logic signed [ANGLE_W-1:0] a_fold;
  logic                      flip;
  logic                      quarter_hit;

  logic signed [XY_W-1:0]    x_q, y_q;
  logic signed [ANGLE_W-1:0] z_q;
  logic [STEP_W-1:0]         i_q;
  logic                      flip_q;

  logic signed [XY_W-1:0]    shx, shy, x_nx, y_nx, x_out;
  logic signed [ANGLE_W-1:0] z_nx, atan_v;

  logic    done_q;
  sincos_t res_q;

  // Fold into [-90, 90] degrees; the cosine sign flips back at the end
  always_comb begin
    if (angle_i > QUARTER_S) begin
      a_fold = HALF_S - angle_i;
      flip   = 1'b1;
    end else if (angle_i < -QUARTER_S) begin
      a_fold = -HALF_S - angle_i;
      flip   = 1'b1;
    end else begin
      a_fold = angle_i;
      flip   = 1'b0;
    end
    quarter_hit = (a_fold == QUARTER_S) || (a_fold == -QUARTER_S);
  end

  always_comb begin
    shx    = x_q >>> i_q;
    shy    = y_q >>> i_q;
    atan_v = atan_deg(i_q);
    if (!z_q[ANGLE_W-1]) begin
      x_nx = x_q - shy;
      y_nx = y_q + shx;
      z_nx = z_q - atan_v;
    end else begin
      x_nx = x_q + shy;
      y_nx = y_q - shx;
      z_nx = z_q + atan_v;
    end
    x_out = flip_q ? -x_q : x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= quarter_hit ? C_FINISH : C_RUN;
          end
        end
        C_RUN: begin
          if (i_q == STEP_LAST) begin
            state_q <= C_FINISH;
          end
        end
        C_FINISH: begin
          res_q.sine   <= round_q30(y_q);
          res_q.cosine <= round_q30(x_out);
          done_q       <= 1'b1;
          state_q      <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && start_i) begin
      flip_q <= flip;
      z_q    <= a_fold;
      i_q    <= '0;
      if (quarter_hit) begin
        x_q <= '0;
        y_q <= a_fold[ANGLE_W-1] ? -ONE_Q30 : ONE_Q30;
      end else begin
        x_q <= CORDIC_GAIN;
        y_q <= '0;
      end
    end else if (state_q == C_RUN) begin
      x_q <= x_nx;
      y_q <= y_nx;
      z_q <= z_nx;
      i_q <= i_q + STEP_W'(1);
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/ypcb_mulq15.sv @@
`timescale 1ns / 1ps
// Shared Q1.15 multiplier with round-half-up and saturation.
// Depends on ypcb_pkg.
module ypcb_mulq15 (
  input  logic signed [ypcb_pkg::VEC_W-1:0] a_i,
  input  logic signed [ypcb_pkg::VEC_W-1:0] b_i,
  output logic signed [ypcb_pkg::VEC_W-1:0] p_o
);
  import ypcb_pkg::*;

  logic signed [2*VEC_W-1:0] prod;
  logic signed [2*VEC_W:0]   rnd;

  always_comb begin
    prod = a_i * b_i;
    rnd  = {prod[2*VEC_W-1], prod} + (2*VEC_W+1)'(16384);
    p_o  = sat16(rnd[2*VEC_W:15]);
  end

endmodule

@@ rtl/ypcb_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the camera basis block, attached by bind.
// Depends on ypcb_pkg and the yaw_pitch_camera_basis top level.
module ypcb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [ypcb_pkg::VEC_W-1:0]   front_x_o,
  input logic signed [ypcb_pkg::VEC_W-1:0]   right_x_o,
  input logic signed [ypcb_pkg::VEC_W-1:0]   right_y_o,
  input logic signed [ypcb_pkg::VEC_W-1:0]   right_z_o,
  input logic signed [ypcb_pkg::VEC_W-1:0]   up_x_o,
  input logic signed [ypcb_pkg::VEC_W-1:0]   up_y_o,
  input logic signed [ypcb_pkg::VEC_W-1:0]   up_z_o,
  input logic [ypcb_pkg::ANGLE_W-1:0]        yaw_now_o,
  input logic                                degenerate_o
);
  import ypcb_pkg::*;

  // a word in work blocks the input side for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in work");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> right_x_o == '0 && right_z_o == '0 &&
      up_x_o == '0 && up_y_o == '0 && up_z_o == '0)
    else $error("degenerate basis with nonzero right or up");

  a_up_y_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |-> up_y_o > 16'sd0 && right_y_o == '0)
    else $error("up_y not positive or right_y not zero");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> yaw_now_o < FULL_U)
    else $error("yaw outside one turn");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(front_x_o) &&
      $stable(yaw_now_o))
    else $error("stalled result changed");

endmodule

bind yaw_pitch_camera_basis ypcb_checker u_ypcb_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for yaw_pitch_camera_basis: drives mouse words and register writes,
// predicts each basis word in its own camera model and checks every output field.
// Depends on ypcb_pkg and the block's RTL only.
module tb_top;

  localparam longint DEG_Q16      = 65536;
  localparam longint TURN_Q16     = 360 * DEG_Q16;
  localparam longint HALF_Q16     = 180 * DEG_Q16;
  localparam longint RIGHT_Q16    = 90 * DEG_Q16;
  localparam longint CLAMP_Q16    = 89 * DEG_Q16;
  localparam longint GAIN_Q30     = 652032874;
  localparam longint UNIT_Q30     = 1073741824;
  localparam int     TRIG_STEPS   = ypcb_pkg::CORDIC_STEPS;
  localparam int     RANDOM_ITEMS = 500;
  localparam int     IDLE_LIMIT   = 6000;
  localparam int     LONG_HOLD    = 400;
  localparam int     DRAIN_CYCLES = 2 * ypcb_pkg::CORDIC_STEPS + 40;
  localparam logic [ypcb_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [ypcb_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } mouse_t;

  typedef struct packed {
    logic signed [15:0] front_x, front_y, front_z;
    logic signed [15:0] right_x, right_y, right_z;
    logic signed [15:0] up_x, up_y, up_z;
    logic [24:0]        yaw_now;
    logic signed [24:0] pitch_now;
    logic               degenerate;
  } basis_t;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ypcb_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [ypcb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] mouse_dx_i = '0;
  logic signed [15:0] mouse_dy_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] front_x_o, front_y_o, front_z_o;
  logic signed [15:0] right_x_o, right_y_o, right_z_o;
  logic signed [15:0] up_x_o, up_y_o, up_z_o;
  logic [24:0]        yaw_now_o;
  logic signed [24:0] pitch_now_o;
  logic               degenerate_o;

  // camera model state and register copies
  longint yaw_deg = 0;
  longint pitch_deg = 0;
  longint sens_q16 = 6554;
  bit     limit_on = 1'b1;
  longint atan_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  mouse_t mouse_pending_q[$];
  basis_t basis_due_q[$];
  mouse_t next_word;
  basis_t want;
  bit     in_fire = 1'b0;
  int     items_queued = 0;
  int     items_taken = 0;
  int     results_seen = 0;
  int     cfg_writes = 0;
  int     degenerate_seen = 0;
  int     failures = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  int     mode_left = 0;
  rx_mode_e ready_mode = RX_ALWAYS;

  yaw_pitch_camera_basis dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mouse_dx_i   (mouse_dx_i),
    .mouse_dy_i   (mouse_dy_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .front_x_o    (front_x_o),
    .front_y_o    (front_y_o),
    .front_z_o    (front_z_o),
    .right_x_o    (right_x_o),
    .right_y_o    (right_y_o),
    .right_z_o    (right_z_o),
    .up_x_o       (up_x_o),
    .up_y_o       (up_y_o),
    .up_z_o       (up_z_o),
    .yaw_now_o    (yaw_now_o),
    .pitch_now_o  (pitch_now_o),
    .degenerate_o (degenerate_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint clamp_q15(input longint v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic longint mul_round_q15(input longint a, input longint b);
    return clamp_q15((a * b + 16384) >>> 15);
  endfunction

  function automatic longint floor_mod(input longint v, input longint m);
    longint r;
    r = v % m;
    if (r < 0) begin
      r += m;
    end
    return r;
  endfunction

  // Sine and cosine in Q1.15 of an angle in [-180,180) degrees, Q.16
  function automatic void trig_q15(input longint ang, output longint sn, output longint cs);
    longint a, x, y, z, nx;
    bit mirror;
    int i;
    a = ang;
    mirror = 1'b0;
    if (a > RIGHT_Q16) begin
      a = HALF_Q16 - a;
      mirror = 1'b1;
    end else if (a < -RIGHT_Q16) begin
      a = -HALF_Q16 - a;
      mirror = 1'b1;
    end
    if (a == RIGHT_Q16 || a == -RIGHT_Q16) begin
      x = 0;
      y = (a > 0) ? UNIT_Q30 : -UNIT_Q30;
    end else begin
      x = GAIN_Q30;
      y = 0;
      z = a;
      for (i = 0; i < TRIG_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_q16[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_q16[i];
        end
        x = nx;
      end
    end
    if (mirror) begin
      x = -x;
    end
    cs = clamp_q15((x + 16384) >>> 15);
    sn = clamp_q15((y + 16384) >>> 15);
  endfunction

  // Advance the stored angles by one mouse word and build the basis
  function automatic basis_t predict_basis(input logic signed [15:0] dx,
                                           input logic signed [15:0] dy);
    longint p, yaw_s, sy, cy, sp, cp, sgn;
    basis_t r;
    yaw_deg = floor_mod(yaw_deg + longint'(dx) * sens_q16, TURN_Q16);
    p = pitch_deg - longint'(dy) * sens_q16;
    if (limit_on) begin
      if (p > CLAMP_Q16) p = CLAMP_Q16;
      if (p < -CLAMP_Q16) p = -CLAMP_Q16;
    end else begin
      p = floor_mod(p + HALF_Q16, TURN_Q16) - HALF_Q16;
    end
    pitch_deg = p;
    yaw_s = (yaw_deg >= HALF_Q16) ? yaw_deg - TURN_Q16 : yaw_deg;
    trig_q15(yaw_s, sy, cy);
    trig_q15(pitch_deg, sp, cp);
    r = '0;
    r.front_x = 16'(mul_round_q15(cy, cp));
    r.front_y = 16'(sp);
    r.front_z = 16'(mul_round_q15(sy, cp));
    r.degenerate = (cp == 0);
    // beyond vertical the cosine goes negative and flips right and up
    if (cp != 0) begin
      sgn = (cp > 0) ? 1 : -1;
      r.right_x = 16'(clamp_q15(-sgn * sy));
      r.right_z = 16'(clamp_q15(sgn * cy));
      r.up_x = 16'(clamp_q15(-sgn * mul_round_q15(cy, sp)));
      r.up_y = 16'(clamp_q15((cp > 0) ? cp : -cp));
      r.up_z = 16'(clamp_q15(-sgn * mul_round_q15(sy, sp)));
    end
    r.yaw_now = 25'(yaw_deg);
    r.pitch_now = 25'(pitch_deg);
    return r;
  endfunction

  function automatic logic signed [15:0] next_count(input bit steer);
    int v;
    if (steer && $urandom_range(0, 4) != 0) begin
      // steps in multiples of 45 degrees land the pitch on exact verticals
      v = 90 * (int'($urandom_range(0, 8)) - 4);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
        4, 5, 6, 7: v = int'($urandom_range(0, 400)) - 200;
        default: begin
          case ($urandom_range(0, 4))
            0: v = -32768;
            1: v = -1;
            2: v = 0;
            3: v = 1;
            default: v = 32767;
          endcase
        end
      endcase
    end
    return 16'(v);
  endfunction

  task automatic send_mouse(input int dx, input int dy);
    mouse_t w;
    w.dx = 16'(dx);
    w.dy = 16'(dy);
    mouse_pending_q.push_back(w);
    items_queued++;
  endtask

  task automatic write_reg(input logic [ypcb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ypcb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every queued word is taken and every basis word is back
  task automatic drain_basis();
    while (!(items_taken == items_queued && results_seen == items_taken)) begin
      @(negedge clk_i);
    end
  endtask

  task automatic compare_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      failures++;
      if (failures <= 10) begin
        $display("%0t: %s mismatch on basis word %0d: expected %0d, got %0d",
                 $time, name, results_seen, exp_v, got_v);
      end
    end
  endtask

  // Accept side: predict on input accept, mirror register writes, check outputs
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) begin
      basis_due_q.push_back(predict_basis(mouse_dx_i, mouse_dy_i));
      items_taken++;
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      cfg_writes++;
      case (cfg_index_i)
        ypcb_pkg::CFG_SENSITIVITY: sens_q16 = longint'(cfg_data_i);
        ypcb_pkg::CFG_PITCH_LIMIT: limit_on = cfg_data_i[0];
        default: ;
      endcase
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (basis_due_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: basis word %0d arrived with nothing pending", $time, results_seen);
        end
      end else begin
        want = basis_due_q.pop_front();
        compare_field("front_x", want.front_x, front_x_o);
        compare_field("front_y", want.front_y, front_y_o);
        compare_field("front_z", want.front_z, front_z_o);
        compare_field("right_x", want.right_x, right_x_o);
        compare_field("right_y", want.right_y, right_y_o);
        compare_field("right_z", want.right_z, right_z_o);
        compare_field("up_x", want.up_x, up_x_o);
        compare_field("up_y", want.up_y, up_y_o);
        compare_field("up_z", want.up_z, up_z_o);
        compare_field("yaw_now", want.yaw_now, yaw_now_o);
        compare_field("pitch_now", want.pitch_now, pitch_now_o);
        compare_field("degenerate", want.degenerate, degenerate_o);
        if (want.degenerate) degenerate_seen++;
      end
    end
  end

  // Mouse word driver: bursts of words separated by random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (mouse_pending_q.size() != 0) begin
        next_word = mouse_pending_q.pop_front();
        in_valid_i <= 1'b1;
        mouse_dx_i <= next_word.dx;
        mouse_dy_i <= next_word.dy;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: stalls on its own pattern, plus one long hold-off while
  // words are still offered so the block backs up into its input
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= 40 && in_valid_i) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (ready_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
        default:   out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n;
    int k;
    int pick;
    int random_items;
    bit steer;
    logic [15:0] sens_pick;
    random_items = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero move and full-scale counts against the clamp
    send_mouse(0, 0);
    send_mouse(32767, 32767);
    send_mouse(-32768, -32768);
    send_mouse(1, -1);
    send_mouse(-1, 1);
    drain_basis();

    // half-degree steps with the clamp off; upper data bits must be ignored
    write_reg(ypcb_pkg::CFG_SENSITIVITY, 16'h8000);
    write_reg(ypcb_pkg::CFG_PITCH_LIMIT, 16'hFFFE);
    send_mouse(180, -180);  // yaw to about 89.9, pitch about 178.9: beyond vertical
    send_mouse(180, -90);   // yaw about 179.9, pitch wraps to about -136.1
    send_mouse(360, -90);   // yaw about 359.9, pitch about -91.1: beyond vertical
    send_mouse(0, -180);    // pitch about -1.1
    send_mouse(0, 90);      // pitch about -46.1
    drain_basis();

    // clamp switched on again while the pitch lies inside the clamp range
    write_reg(ypcb_pkg::CFG_PITCH_LIMIT, 16'h0001);
    send_mouse(0, 0);
    send_mouse(-1, 0);
    drain_basis();

    write_reg(ypcb_pkg::CFG_SENSITIVITY, 16'h0000);
    send_mouse(12345, -23456);
    send_mouse(-32768, 32767);
    drain_basis();

    write_reg(ypcb_pkg::CFG_SENSITIVITY, 16'hFFFF);
    send_mouse(32767, -32768);
    send_mouse(-32768, 32767);
    send_mouse(-1, -1);
    drain_basis();

    // writes to unused indexes change nothing
    write_reg(CFG_SPARE_A, 16'h0000);
    write_reg(CFG_SPARE_B, 16'h0001);
    send_mouse(5, 5);
    drain_basis();

    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      steer = (pick == 9);
      case (pick)
        0, 1, 2: sens_pick = 16'($urandom_range(0, 65535));
        3, 4, 5: sens_pick = 16'($urandom_range(1, 2000));
        6:       sens_pick = 16'h0000;
        7:       sens_pick = 16'hFFFF;
        8:       sens_pick = 16'd6554;
        default: sens_pick = 16'h8000;
      endcase
      write_reg(ypcb_pkg::CFG_SENSITIVITY, sens_pick);
      write_reg(ypcb_pkg::CFG_PITCH_LIMIT, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
      end
      n = $urandom_range(30, 70);
      for (k = 0; k < n; k++) begin
        send_mouse(next_count(steer), next_count(steer));
      end
      random_items += n;
      drain_basis();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    failures += basis_due_q.size();
    $display("Run drove %0d mouse words and %0d register writes", items_taken, cfg_writes);
    $display("Checked %0d basis words, %0d of them degenerate", results_seen,
             degenerate_seen);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
